/* hw/rtl/sv39ptm_pkg.sv */
package sv39ptm_pkg;

    localparam int TABLE_PAGES       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int MAX_PAGE_COUNT    = 4096;

    localparam int PTE_W   = 54;
    localparam int PPN_W   = 44;
    localparam int VA_W    = 27;
    localparam int FLAG_W  = 10;
    localparam int COUNT_W = 13;

    localparam int VPN_W       = $clog2(ENTRIES_PER_TABLE);
    localparam int SLOT_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int NFT_W       = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W      = SLOT_W + VPN_W;
    localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

    localparam logic [PPN_W-1:0] BASE_PPN_RESET = 44'd524288;

    localparam logic REQ_MAP    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NOT_MAPPED = 2'd1,
        STAT_EXHAUSTED  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        W_IDLE,
        W_RD_L2,
        W_CHK_L2,
        W_RD_L1,
        W_CHK_L1,
        W_WR_LEAF,
        W_CHK_LEAF,
        W_DONE
    } walk_state_t;

    typedef struct packed {
        logic               req_type;
        logic [VA_W-1:0]    virt_page;
        logic [PPN_W-1:0]   phys_page;
        logic [COUNT_W-1:0] page_count;
        logic [FLAG_W-1:0]  perm_flags;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [PTE_W-1:0]   leaf_entry;
        logic [COUNT_W-1:0] pages_done;
    } res_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PTE_W-1:0]  wdata;
    } mem_req_t;

endpackage

/* hw/rtl/sv39_page_table_mapper.sv */
// Per page the walker steps through store reads L2, L1 and the leaf write on one
// single-read, single-write table memory; a missing L2 pointer adds the W_RD_L1 step.
// Throughput: one request at a time; s_ready rises again in the same cycle as m_valid rises,
// and a finished result in the output register does not block the next input transfer.
// Reset: synchronous active low; store clear pass over all TABLE_PAGES*512 (8192) entries, s_ready low.
module sv39_page_table_mapper (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    // request channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_req_type,
    input  logic [sv39ptm_pkg::VA_W-1:0]            s_virt_page,
    input  logic [sv39ptm_pkg::PPN_W-1:0]           s_phys_page,
    input  logic [sv39ptm_pkg::COUNT_W-1:0]         s_page_count,
    input  logic [sv39ptm_pkg::FLAG_W-1:0]          s_perm_flags,

    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [1:0]                              m_status,
    output logic [sv39ptm_pkg::PTE_W-1:0]           m_leaf_entry,
    output logic [sv39ptm_pkg::COUNT_W-1:0]         m_pages_done,

    // table_base_ppn write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [sv39ptm_pkg::PPN_W-1:0]           cfg_data
);

    sv39ptm_pkg::req_t      req;
    sv39ptm_pkg::res_t      res;
    sv39ptm_pkg::mem_req_t  mem_req;
    logic [sv39ptm_pkg::PTE_W-1:0] rd_data;
    logic                   clearing;
    logic                   res_valid;
    logic                   res_ready;

    // base register: the user must write it only while idle (not enforced here), so always ready
    logic [sv39ptm_pkg::PPN_W-1:0] base_ppn_reg, base_ppn_next;

    assign cfg_ready     = 1'b1;
    assign base_ppn_next = (cfg_valid && cfg_ready) ? cfg_data : base_ppn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_ppn_reg <= sv39ptm_pkg::BASE_PPN_RESET;
        end else begin
            base_ppn_reg <= base_ppn_next;
        end
    end

    assign req.req_type   = s_req_type;
    assign req.virt_page  = s_virt_page;
    assign req.phys_page  = s_phys_page;
    assign req.page_count = s_page_count;
    assign req.perm_flags = s_perm_flags;

    sv39ptm_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    sv39ptm_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .base_ppn  (base_ppn_reg),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: parts the walker from the result transfer
    logic                                m_valid_reg, m_valid_next;
    sv39ptm_pkg::res_t                   out_reg, out_next;
    logic                                out_load;

    assign res_ready = !m_valid_reg || m_ready;
    assign out_load  = res_valid && res_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_reg.status;
    assign m_leaf_entry = out_reg.leaf_entry;
    assign m_pages_done = out_reg.pages_done;

endmodule

/* hw/rtl/sv39ptm_store.sv */
// Table store: one write and one registered read per cycle.
// Sweeps every entry to zero after reset.
module sv39ptm_store (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sv39ptm_pkg::mem_req_t                 mem_req,
    output logic [sv39ptm_pkg::PTE_W-1:0]         rd_data,
    output logic                                  clearing
);

    logic [sv39ptm_pkg::PTE_W-1:0] mem [0:sv39ptm_pkg::STORE_DEPTH-1];
    logic [sv39ptm_pkg::PTE_W-1:0] rd_data_reg;

    logic                           clr_active_reg, clr_active_next;
    logic [sv39ptm_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + sv39ptm_pkg::ADDR_W'(1);
            if (clr_addr_reg == sv39ptm_pkg::ADDR_W'(sv39ptm_pkg::STORE_DEPTH - 1)) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_req.re) begin
            rd_data_reg <= mem[mem_req.raddr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_active_reg;

endmodule

/* hw/rtl/sv39ptm_walker.sv */
// Walk sequencer: reads, checks and allocates table entries one step at a time.
module sv39ptm_walker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  sv39ptm_pkg::req_t                     req,
    input  logic [sv39ptm_pkg::PPN_W-1:0]         base_ppn,
    output sv39ptm_pkg::mem_req_t                 mem_req,
    input  logic [sv39ptm_pkg::PTE_W-1:0]         rd_data,
    input  logic                                  clearing,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output sv39ptm_pkg::res_t                     res
);

    localparam int VPN_W   = sv39ptm_pkg::VPN_W;
    localparam int VA_W    = sv39ptm_pkg::VA_W;
    localparam int PPN_W   = sv39ptm_pkg::PPN_W;
    localparam int FLAG_W  = sv39ptm_pkg::FLAG_W;
    localparam int COUNT_W = sv39ptm_pkg::COUNT_W;
    localparam int SLOT_W  = sv39ptm_pkg::SLOT_W;
    localparam int NFT_W   = sv39ptm_pkg::NFT_W;

    sv39ptm_pkg::walk_state_t state_reg, state_next;

    logic [NFT_W-1:0]                nft_reg, nft_next;
    logic                            lookup_reg, lookup_next;
    logic [VA_W-1:0]                 vpn_reg, vpn_next;
    logic [PPN_W-1:0]                ppn_reg, ppn_next;
    logic [FLAG_W-1:0]               flags_reg, flags_next;
    logic [COUNT_W-1:0]              count_reg, count_next;
    logic [COUNT_W-1:0]              done_reg, done_next;
    logic [SLOT_W-1:0]               slot_reg, slot_next;
    sv39ptm_pkg::status_t            status_reg, status_next;
    logic [sv39ptm_pkg::PTE_W-1:0]   entry_reg, entry_next;

    logic                req_fire;
    logic [COUNT_W-1:0]  count_sat;
    logic [PPN_W-1:0]    pte_off;
    logic                ptr_ok;
    logic                exhausted;
    logic                last_page;
    logic [VPN_W-1:0]    idx2, idx1, idx0;
    logic [SLOT_W-1:0]   off_slot, nft_slot;
    logic [sv39ptm_pkg::PTE_W-1:0] ptr_pte, leaf_pte;

    assign req_ready = (state_reg == sv39ptm_pkg::W_IDLE) && !clearing;
    assign req_fire  = req_valid && req_ready;

    assign count_sat = (32'(req.page_count) > sv39ptm_pkg::MAX_PAGE_COUNT) ?
                       COUNT_W'(sv39ptm_pkg::MAX_PAGE_COUNT) : req.page_count;

    assign idx2 = vpn_reg[VA_W-1 -: VPN_W];
    assign idx1 = vpn_reg[2*VPN_W-1 -: VPN_W];
    assign idx0 = vpn_reg[VPN_W-1:0];

    // pointer counts only if it names an allocated pool slot
    assign pte_off   = rd_data[sv39ptm_pkg::PTE_W-1:FLAG_W] - base_ppn;
    assign ptr_ok    = rd_data[0] && (pte_off < PPN_W'(nft_reg));
    assign off_slot  = pte_off[SLOT_W-1:0];
    assign nft_slot  = nft_reg[SLOT_W-1:0];
    assign exhausted = nft_reg >= NFT_W'(sv39ptm_pkg::TABLE_PAGES);
    assign last_page = (done_reg + COUNT_W'(1)) == count_reg;

    assign ptr_pte  = {base_ppn + PPN_W'(nft_reg), {(FLAG_W-1){1'b0}}, 1'b1};
    assign leaf_pte = {ppn_reg, flags_reg | FLAG_W'(1)};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sv39ptm_pkg::W_IDLE: begin
                if (req_fire) begin
                    if (req.req_type == sv39ptm_pkg::REQ_MAP && count_sat == '0) begin
                        state_next = sv39ptm_pkg::W_DONE;
                    end else begin
                        state_next = sv39ptm_pkg::W_RD_L2;
                    end
                end
            end
            sv39ptm_pkg::W_RD_L2: state_next = sv39ptm_pkg::W_CHK_L2;
            sv39ptm_pkg::W_CHK_L2: begin
                priority if (ptr_ok)     state_next = sv39ptm_pkg::W_CHK_L1;
                else if (lookup_reg)     state_next = sv39ptm_pkg::W_DONE;
                else if (exhausted)      state_next = sv39ptm_pkg::W_DONE;
                else                     state_next = sv39ptm_pkg::W_RD_L1;
            end
            sv39ptm_pkg::W_RD_L1: state_next = sv39ptm_pkg::W_CHK_L1;
            sv39ptm_pkg::W_CHK_L1: begin
                priority if (lookup_reg) begin
                    state_next = ptr_ok ? sv39ptm_pkg::W_CHK_LEAF : sv39ptm_pkg::W_DONE;
                end else if (ptr_ok) begin
                    state_next = sv39ptm_pkg::W_WR_LEAF;
                end else if (exhausted) begin
                    state_next = sv39ptm_pkg::W_DONE;
                end else begin
                    state_next = sv39ptm_pkg::W_WR_LEAF;
                end
            end
            sv39ptm_pkg::W_WR_LEAF: begin
                state_next = last_page ? sv39ptm_pkg::W_DONE : sv39ptm_pkg::W_RD_L2;
            end
            sv39ptm_pkg::W_CHK_LEAF: state_next = sv39ptm_pkg::W_DONE;
            sv39ptm_pkg::W_DONE: begin
                if (res_ready) state_next = sv39ptm_pkg::W_IDLE;
            end
            default: state_next = sv39ptm_pkg::W_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        nft_next    = nft_reg;
        lookup_next = lookup_reg;
        vpn_next    = vpn_reg;
        ppn_next    = ppn_reg;
        flags_next  = flags_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        slot_next   = slot_reg;
        status_next = status_reg;
        entry_next  = entry_reg;
        unique case (state_reg)
            sv39ptm_pkg::W_IDLE: begin
                if (req_fire) begin
                    lookup_next = (req.req_type == sv39ptm_pkg::REQ_LOOKUP);
                    vpn_next    = req.virt_page;
                    ppn_next    = req.phys_page;
                    flags_next  = req.perm_flags;
                    count_next  = count_sat;
                    done_next   = '0;
                    slot_next   = '0;
                    status_next = sv39ptm_pkg::STAT_OK;
                    entry_next  = '0;
                end
            end
            sv39ptm_pkg::W_CHK_L2, sv39ptm_pkg::W_CHK_L1: begin
                priority if (ptr_ok) begin
                    slot_next = off_slot;
                end else if (lookup_reg) begin
                    status_next = sv39ptm_pkg::STAT_NOT_MAPPED;
                end else if (exhausted) begin
                    status_next = sv39ptm_pkg::STAT_EXHAUSTED;
                end else begin
                    slot_next = nft_slot;
                    nft_next  = nft_reg + NFT_W'(1);
                end
            end
            sv39ptm_pkg::W_WR_LEAF: begin
                done_next = done_reg + COUNT_W'(1);
                vpn_next  = vpn_reg + VA_W'(1);
                ppn_next  = ppn_reg + PPN_W'(1);
            end
            sv39ptm_pkg::W_CHK_LEAF: begin
                if (rd_data[0]) entry_next  = rd_data;
                else            status_next = sv39ptm_pkg::STAT_NOT_MAPPED;
            end
            sv39ptm_pkg::W_RD_L2, sv39ptm_pkg::W_RD_L1, sv39ptm_pkg::W_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // store accesses and result
    always_comb begin
        mem_req   = '0;
        res_valid = 1'b0;
        unique case (state_reg)
            sv39ptm_pkg::W_RD_L2: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = {SLOT_W'(0), idx2};
            end
            sv39ptm_pkg::W_CHK_L2: begin
                if (ptr_ok) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = {off_slot, idx1};
                end else if (!lookup_reg && !exhausted) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = {SLOT_W'(0), idx2};
                    mem_req.wdata = ptr_pte;
                end
            end
            sv39ptm_pkg::W_RD_L1: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = {slot_reg, idx1};
            end
            sv39ptm_pkg::W_CHK_L1: begin
                if (ptr_ok && lookup_reg) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = {off_slot, idx0};
                end else if (!ptr_ok && !lookup_reg && !exhausted) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = {slot_reg, idx1};
                    mem_req.wdata = ptr_pte;
                end
            end
            sv39ptm_pkg::W_WR_LEAF: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = {slot_reg, idx0};
                mem_req.wdata = leaf_pte;
            end
            sv39ptm_pkg::W_DONE: res_valid = 1'b1;
            sv39ptm_pkg::W_IDLE, sv39ptm_pkg::W_CHK_LEAF: begin
            end
            default: begin
            end
        endcase
    end

    assign res.status     = status_reg;
    assign res.leaf_entry = entry_reg;
    assign res.pages_done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sv39ptm_pkg::W_IDLE;
            nft_reg   <= NFT_W'(1);
        end else begin
            state_reg <= state_next;
            nft_reg   <= nft_next;
        end
    end

    always_ff @(posedge aclk) begin
        lookup_reg <= lookup_next;
        vpn_reg    <= vpn_next;
        ppn_reg    <= ppn_next;
        flags_reg  <= flags_next;
        count_reg  <= count_next;
        done_reg   <= done_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        entry_reg  <= entry_next;
    end

endmodule
